[rtl/ptt_pkg.sv]
// ---------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the periodic task timer table
// Slot record, command and status codes, default sizes.
// ---------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  // default sizes
  localparam int unsigned TABLE_SLOTS_DEF = 16;
  localparam int unsigned TICK_MS_DEF     = 10;

  // field widths
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RUNS_W   = 8;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned SEL_W    = 8;

  // results per dispatch request, reciprocal divide steps per add
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned DIV_STEPS   = 2;

  typedef enum logic [2:0] {
    CMD_ADD      = 3'd0,
    CMD_DELETE   = 3'd1,
    CMD_TICK     = 3'd2,
    CMD_DISPATCH = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_FULL   = 2'd1,
    ERR_DELETE = 2'd2
  } err_e;

  // one timer slot; free when handle is zero
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   delay;
    logic [TIME_W-1:0]   period;
    logic [RUNS_W-1:0]   runs;
  } slot_t;

endpackage

`default_nettype wire

[rtl/ptt_div.sv]
// ---------------------------------------------------------------------------
// ptt_div: divider by a fixed constant
// Reciprocal multiplication in two steps, one half of the dividend per step.
// ---------------------------------------------------------------------------
`default_nettype none

module ptt_div #(
  parameter int unsigned DIVISOR = 10,
  parameter int unsigned WIDTH   = 32
) (
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire logic             step_i,
  input  wire logic [WIDTH-1:0] dividend_i,
  output logic      [WIDTH-1:0] quot_o
);
  // q = (x * M) >> SH with M = ceil(2^SH / DIVISOR), exact for every x
  localparam int unsigned LW = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
  localparam int unsigned SH = WIDTH + LW;
  localparam int unsigned MW = WIDTH + 1;
  localparam int unsigned PW = 2 * WIDTH + 1;
  localparam int unsigned HW = WIDTH / 2;
  localparam logic [PW-1:0] ONE_SH  = PW'(1) << SH;
  localparam logic [PW-1:0] RECIP_W = (ONE_SH + PW'(DIVISOR) - PW'(1)) / PW'(DIVISOR);
  localparam logic [MW-1:0] RECIP   = RECIP_W[MW-1:0];

  logic [WIDTH-1:0]       x_q, x_d;
  logic [PW-1:0]          acc_q, acc_d;
  logic                   ph_q, ph_d;
  logic [HW+MW-1:0]       lo_prod;
  logic [WIDTH-HW+MW-1:0] hi_prod;
  logic [PW-1:0]          acc_sh;

  // low half on the first step, shifted high half added on the second
  always_comb begin
    lo_prod = {{MW{1'b0}}, x_q[HW-1:0]} * {{HW{1'b0}}, RECIP};
    hi_prod = {{MW{1'b0}}, x_q[WIDTH-1:HW]} * {{(WIDTH-HW){1'b0}}, RECIP};
    x_d     = x_q;
    acc_d   = acc_q;
    ph_d    = ph_q;
    if (load_i) begin
      x_d   = dividend_i;
      acc_d = '0;
      ph_d  = 1'b0;
    end else if (step_i) begin
      if (!ph_q) begin
        acc_d = PW'(lo_prod);
      end else begin
        acc_d = acc_q + {hi_prod, {HW{1'b0}}};
      end
      ph_d = !ph_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    acc_q <= acc_d;
    ph_q  <= ph_d;
  end

  assign acc_sh = acc_q >> SH;
  assign quot_o = acc_sh[WIDTH-1:0];

endmodule

`default_nettype wire

[rtl/ptt_cell.sv]
// ---------------------------------------------------------------------------
// ptt_cell: one slot of the timer ring
// Holds a slot record and takes its neighbour's record on every shift.
// ---------------------------------------------------------------------------
`default_nettype none

module ptt_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           shift_i,
  input  wire logic           clear_i,
  input  wire ptt_pkg::slot_t slot_i,
  output ptt_pkg::slot_t      slot_o
);
  import ptt_pkg::*;

  slot_t slot_q, slot_d;

  // clear wins over shift
  always_comb begin
    slot_d = slot_q;
    if (clear_i) begin
      slot_d = '0;
    end else if (shift_i) begin
      slot_d = slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire

[rtl/periodic_task_timer_table_core.sv]
// ---------------------------------------------------------------------------
// periodic_task_timer_table_core: ring of timed task slots
// Add, delete, tick, dispatch and clear-all on a rotating row of slots.
// ---------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low. Its
// results leave on result_strobe_o, each valid for exactly one cycle;
// the receiver cannot hold them off and there is no stall path.
// The slots sit in a ring of TABLE_SLOTS cells that, during a pass, rotates
// one place per cycle past a single processing head, so one pass visits
// every slot once. Steps of each request (N = TABLE_SLOTS):
//   add                       : two-step reciprocal divide of both times
//                               by TICK_MS, one pass of N slots, closing
//   delete, tick, dispatch    : one pass, a closing state, result
//   clear all, bad slot delete: result straight from idle, busy stays low
//   commands 5 to 7           : ignored, no result
// Busy is high after acceptance up to and including the closing state; the
// last result is on the ports in the first cycle with busy low. Dispatch
// results come out during the pass, the final one from the closing state,
// marked by last_of_run_o. Reset empties every slot and clears the sticky error.
// ---------------------------------------------------------------------------
`default_nettype none

module periodic_task_timer_table_core #(
  parameter int unsigned TABLE_SLOTS = ptt_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned TICK_MS     = ptt_pkg::TICK_MS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    command_i,
  input  wire logic [ptt_pkg::HANDLE_W-1:0]  task_handle_i,
  input  wire logic [ptt_pkg::TIME_W-1:0]    start_delay_ms_i,
  input  wire logic [ptt_pkg::TIME_W-1:0]    repeat_period_ms_i,
  input  wire logic [ptt_pkg::SEL_W-1:0]     slot_select_i,
  output logic                               result_strobe_o,
  output logic [1:0]                         status_o,
  output logic [ptt_pkg::SLOT_W-1:0]         slot_number_o,
  output logic [ptt_pkg::HANDLE_W-1:0]       run_handle_o,
  output logic                               run_valid_o,
  output logic                               last_of_run_o,
  output logic [1:0]                         sticky_error_o
);
  import ptt_pkg::*;

  localparam int unsigned IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(DIV_STEPS);
  localparam int unsigned NW = $clog2(MAX_RESULTS + 1);
  localparam logic [SEL_W-1:0] SLOTS_SEL = SEL_W'(TABLE_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  typedef struct packed {
    logic                strobe;
    logic [1:0]          status;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic                valid;
    logic                last;
    logic [1:0]          sticky;
  } res_t;

  state_e              state_q, state_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [NW-1:0]       nres_q, nres_d;
  logic [2:0]          cmd_q, cmd_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [SEL_W-1:0]    sel_q, sel_d;
  logic                found_q, found_d;
  logic                empty_q, empty_d;
  logic                hold_v_q, hold_v_d;
  logic [SLOT_W-1:0]   hold_slot_q, hold_slot_d;
  logic [HANDLE_W-1:0] hold_handle_q, hold_handle_d;
  err_e                err_q, err_d;
  res_t                res_q, res_d;

  logic                accept;
  logic                div_load, div_step;
  logic                ring_shift, ring_clear;
  logic                last_slot;
  logic [TIME_W-1:0]   dly_ticks, per_ticks;
  slot_t               head, head_new;
  slot_t               cell_out [TABLE_SLOTS];
  slot_t               cell_in  [TABLE_SLOTS];

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // dividers turning milliseconds into ticks
  ptt_div #(.DIVISOR(TICK_MS), .WIDTH(TIME_W)) u_div_dly (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (div_step),
    .dividend_i (start_delay_ms_i),
    .quot_o     (dly_ticks)
  );

  ptt_div #(.DIVISOR(TICK_MS), .WIDTH(TIME_W)) u_div_per (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (div_step),
    .dividend_i (repeat_period_ms_i),
    .quot_o     (per_ticks)
  );

  // slot ring: each cell takes its upper neighbour, the top takes the head
  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_ring
    if (g == TABLE_SLOTS - 1) begin : g_top
      assign cell_in[g] = head_new;
    end else begin : g_mid
      assign cell_in[g] = cell_out[g+1];
    end
    ptt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring_shift),
      .clear_i (ring_clear),
      .slot_i  (cell_in[g]),
      .slot_o  (cell_out[g])
    );
  end

  assign head      = cell_out[0];
  assign last_slot = (idx_q == IW'(TABLE_SLOTS - 1));

  // sequencer and head processing
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    nres_d        = nres_q;
    cmd_d         = cmd_q;
    handle_d      = handle_q;
    sel_d         = sel_q;
    found_d       = found_q;
    empty_d       = empty_q;
    hold_v_d      = hold_v_q;
    hold_slot_d   = hold_slot_q;
    hold_handle_d = hold_handle_q;
    err_d         = err_q;
    div_load      = 1'b0;
    div_step      = 1'b0;
    ring_shift    = 1'b0;
    ring_clear    = 1'b0;
    head_new      = head;
    res_d         = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d    = command_i;
          handle_d = task_handle_i;
          sel_d    = slot_select_i;
          idx_d    = '0;
          cnt_d    = '0;
          nres_d   = '0;
          found_d  = 1'b0;
          empty_d  = 1'b0;
          hold_v_d = 1'b0;
          case (command_i) inside
            CMD_ADD: begin
              div_load = 1'b1;
              state_d  = S_DIV;
            end
            CMD_DELETE: begin
              if (slot_select_i >= SLOTS_SEL) begin
                err_d        = ERR_DELETE;
                res_d.strobe = 1'b1;
                res_d.status = ST_RANGE;
                res_d.last   = 1'b1;
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_TICK, CMD_DISPATCH: begin
              state_d = S_SCAN;
            end
            CMD_CLEAR: begin
              ring_clear   = 1'b1;
              err_d        = ERR_NONE;
              res_d.strobe = 1'b1;
              res_d.last   = 1'b1;
            end
            default: ;
          endcase
        end
      end

      S_DIV: begin
        div_step = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_STEPS - 1)) begin
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        ring_shift = 1'b1;
        idx_d      = idx_q + 1'b1;
        if (last_slot) begin
          idx_d   = '0;
          state_d = S_FIN;
        end
        case (cmd_q)
          CMD_ADD: begin
            // first free slot takes the new task
            if (!found_q && head.handle == '0) begin
              head_new.handle = handle_q;
              head_new.delay  = dly_ticks;
              head_new.period = per_ticks;
              head_new.runs   = '0;
              found_d         = 1'b1;
              hold_slot_d     = SLOT_W'(idx_q);
            end
          end
          CMD_DELETE: begin
            if (SEL_W'(idx_q) == sel_q) begin
              empty_d  = (head.handle == '0);
              head_new = '0;
            end
          end
          CMD_TICK: begin
            if (head.handle != '0) begin
              if (head.delay == '0) begin
                if (head.runs != '1) begin
                  head_new.runs = head.runs + 1'b1;
                end
                if (head.period != '0) begin
                  head_new.delay = head.period;
                end
              end else begin
                head_new.delay = head.delay - 1'b1;
              end
            end
          end
          CMD_DISPATCH: begin
            // a held result goes out once a later one is known
            if (head.runs != '0 && nres_q < NW'(MAX_RESULTS)) begin
              if (hold_v_q) begin
                res_d.strobe = 1'b1;
                res_d.status = ST_OK;
                res_d.slot   = hold_slot_q;
                res_d.handle = hold_handle_q;
                res_d.valid  = 1'b1;
              end
              hold_v_d      = 1'b1;
              hold_slot_d   = SLOT_W'(idx_q);
              hold_handle_d = head.handle;
              nres_d        = nres_q + 1'b1;
              head_new.runs = head.runs - 1'b1;
              if (head.period == '0) begin
                head_new = '0;
              end
            end
          end
          default: ;
        endcase
      end

      S_FIN: begin
        state_d      = S_IDLE;
        res_d.strobe = 1'b1;
        res_d.last   = 1'b1;
        case (cmd_q)
          CMD_ADD: begin
            if (found_q) begin
              res_d.slot = hold_slot_q;
            end else begin
              err_d        = ERR_FULL;
              res_d.status = ST_FULL;
              res_d.slot   = SLOT_W'(TABLE_SLOTS);
            end
          end
          CMD_DELETE: begin
            res_d.slot = SLOT_W'(sel_q);
            if (empty_q) begin
              err_d        = ERR_DELETE;
              res_d.status = ST_EMPTY;
            end
          end
          CMD_DISPATCH: begin
            if (hold_v_q) begin
              res_d.slot   = hold_slot_q;
              res_d.handle = hold_handle_q;
              res_d.valid  = 1'b1;
            end
          end
          default: ;
        endcase
      end

      default: state_d = S_IDLE;
    endcase

    res_d.sticky = err_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      cnt_q    <= '0;
      nres_q   <= '0;
      found_q  <= 1'b0;
      empty_q  <= 1'b0;
      hold_v_q <= 1'b0;
      err_q    <= ERR_NONE;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      nres_q   <= nres_d;
      found_q  <= found_d;
      empty_q  <= empty_d;
      hold_v_q <= hold_v_d;
      err_q    <= err_d;
      res_q    <= res_d;
    end
  end

  // request payload and held dispatch result
  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    handle_q      <= handle_d;
    sel_q         <= sel_d;
    hold_slot_q   <= hold_slot_d;
    hold_handle_q <= hold_handle_d;
  end

  assign result_strobe_o = res_q.strobe;
  assign status_o        = res_q.status;
  assign slot_number_o   = res_q.slot;
  assign run_handle_o    = res_q.handle;
  assign run_valid_o     = res_q.valid;
  assign last_of_run_o   = res_q.last;
  assign sticky_error_o  = res_q.sticky;

endmodule

`default_nettype wire

[rtl/ptt_checker.sv]
// ---------------------------------------------------------------------------
// ptt_checker: port-level checks of the timer table
// Consistency of status, sticky error and run marks on each result.
// ---------------------------------------------------------------------------
`default_nettype none

module ptt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       result_strobe_o,
  input wire logic [1:0] status_o,
  input wire logic       run_valid_o,
  input wire logic       last_of_run_o,
  input wire logic [1:0] sticky_error_o
);
  import ptt_pkg::*;

  // a task to run only comes with an ok status
  a_run_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && run_valid_o |-> status_o == ST_OK)
    else $error("run result with error status");

  // full table raises the matching sticky error on a single result
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && status_o == ST_FULL |-> sticky_error_o == ERR_FULL && last_of_run_o)
    else $error("full status without matching sticky error");

  // failed delete raises the delete error
  a_del: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && (status_o == ST_EMPTY || status_o == ST_RANGE)
      |-> sticky_error_o == ERR_DELETE)
    else $error("delete failure without sticky error");

  // only dispatch gives several results; anything else ends the request
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !run_valid_o |-> last_of_run_o)
    else $error("non-run result not marked last");

  // a final result closes the request: busy with it means a new request was taken
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && last_of_run_o && busy |-> $past(start) && !$past(busy))
    else $error("block busy after final result without a new request");

endmodule

bind periodic_task_timer_table_core ptt_checker u_ptt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_strobe_o (result_strobe_o),
  .status_o        (status_o),
  .run_valid_o     (run_valid_o),
  .last_of_run_o   (last_of_run_o),
  .sticky_error_o  (sticky_error_o)
);

`default_nettype wire
